// File: design/cnrf_pkg.sv
// ----------------------------------------------------------------------------
// cnrf_pkg
// shared types and constants for the cubic newton root finder
// ----------------------------------------------------------------------------
package cnrf_pkg;

	localparam int unsigned WordW = 48;
	localparam int unsigned TolW  = 47;
	localparam int unsigned IterW = 16;

	localparam logic [1:0] StatusConverged = 2'd0;
	localparam logic [1:0] StatusFlat      = 2'd1;
	localparam logic [1:0] StatusLimit     = 2'd2;

	localparam logic [2:0] RegConstant = 3'd0;
	localparam logic [2:0] RegLinear   = 3'd1;
	localparam logic [2:0] RegSquare   = 3'd2;
	localparam logic [2:0] RegCube     = 3'd3;
	localparam logic [2:0] RegTol      = 3'd4;
	localparam logic [2:0] RegMaxIter  = 3'd5;

	localparam logic signed [WordW-1:0] PosMax = {1'b0, {(WordW-1){1'b1}}};
	localparam logic signed [WordW-1:0] NegMin = {1'b1, {(WordW-1){1'b0}}};

	// arithmetic unit operations
	typedef enum logic [1:0] {
		OpMul,
		OpDiv,
		OpAdd,
		OpSub
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_cmd_t;

	// saturate a wide signed value to the word range
	function automatic logic signed [WordW-1:0] sat50(input logic signed [WordW+1:0] v);
		logic signed [WordW+1:0] hi;
		logic signed [WordW+1:0] lo;
		hi = {{2{PosMax[WordW-1]}}, PosMax};
		lo = {{2{NegMin[WordW-1]}}, NegMin};
		if (v > hi) begin
			return PosMax;
		end else if (v < lo) begin
			return NegMin;
		end
		return v[WordW-1:0];
	endfunction

	// apply sign to an unsigned magnitude of word+1 bits, saturating
	function automatic logic signed [WordW-1:0] apply_sign(input logic [WordW:0] mag,
		input logic neg);
		logic [WordW:0] lim;
		lim = {2'b01, {(WordW-1){1'b0}}};
		if (neg) begin
			if (mag >= lim) begin
				return NegMin;
			end
			return -$signed(mag[WordW-1:0]);
		end
		if (mag >= lim) begin
			return PosMax;
		end
		return mag[WordW-1:0];
	endfunction

endpackage

// File: design/cnrf_alu.sv
// ----------------------------------------------------------------------------
// cnrf_alu
// shared saturating fixed-point unit: multiply, divide, add and subtract
// ----------------------------------------------------------------------------
module cnrf_alu #(
	parameter int unsigned FRACTION_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cnrf_pkg::alu_cmd_t                  cmd,
	input  logic signed [cnrf_pkg::WordW-1:0]   a,
	input  logic signed [cnrf_pkg::WordW-1:0]   b,
	output logic                                done,
	output logic signed [cnrf_pkg::WordW-1:0]   result
);
	localparam int unsigned W   = cnrf_pkg::WordW;
	localparam int unsigned PW  = 2 * W;              // product width
	localparam int unsigned NW  = W + FRACTION_BITS;  // dividend width
	localparam int unsigned CW  = $clog2(PW + 1);

	typedef enum logic [1:0] {
		Idle,
		MulRun,
		DivRun
	} alu_state_t;

	alu_state_t      state_q;
	logic [CW-1:0]   cnt_q;
	logic            neg_q;
	logic [W-1:0]    ma_q;        // multiplicand or divisor magnitude
	logic [PW-1:0]   acc_q;       // product accumulator
	logic [W-1:0]    mb_q;        // multiplier bits, shifted out lsb first
	logic [NW-1:0]   num_q;       // dividend bits, shifted out msb first
	logic [W:0]      rem_q;
	logic [W:0]      quo_q;       // stops shifting once it reaches 2^W

	logic [W-1:0]    mag_a;
	logic [W-1:0]    mag_b;
	logic [PW:0]     acc_sum;     // one bit wider to keep the carry
	logic [PW-1:0]   acc_next;
	logic [W:0]      rem_sh;
	logic            qb;
	logic [W:0]      rem_next;
	logic [PW-1:0]   prod_sh;
	logic [W:0]      mul_mag;

	always_comb begin
		mag_a = a[W-1] ? W'(-a) : W'(a);
		mag_b = b[W-1] ? W'(-b) : W'(b);
		acc_sum = mb_q[0] ? {1'b0, acc_q} + {1'b0, ma_q, {W{1'b0}}} : {1'b0, acc_q};
		acc_next = acc_sum[PW:1];
		rem_sh = {rem_q[W-1:0], num_q[NW-1]};
		qb = (rem_sh >= {1'b0, ma_q});
		rem_next = qb ? rem_sh - {1'b0, ma_q} : rem_sh;
		prod_sh = acc_q >> FRACTION_BITS;
		mul_mag = (prod_sh[PW-1:W] != '0) ? {1'b1, {W{1'b0}}} : {1'b0, prod_sh[W-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= Idle;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				Idle: begin
					if (cmd.start) begin
						case (cmd.op)
							cnrf_pkg::OpMul: begin
								neg_q   <= a[W-1] ^ b[W-1];
								ma_q    <= mag_a;
								mb_q    <= mag_b;
								acc_q   <= '0;
								cnt_q   <= CW'(W);
								state_q <= MulRun;
							end
							cnrf_pkg::OpDiv: begin
								neg_q <= a[W-1] ^ b[W-1];
								if (mag_b == '0) begin
									result <= (a == '0) ? '0 :
										(a[W-1] ? cnrf_pkg::NegMin : cnrf_pkg::PosMax);
									done   <= 1'b1;
								end else begin
									ma_q    <= mag_b;
									num_q   <= {mag_a, {FRACTION_BITS{1'b0}}};
									rem_q   <= '0;
									quo_q   <= '0;
									cnt_q   <= CW'(NW);
									state_q <= DivRun;
								end
							end
							cnrf_pkg::OpAdd: begin
								result <= cnrf_pkg::sat50((W+2)'(a) + (W+2)'(b));
								done   <= 1'b1;
							end
							cnrf_pkg::OpSub: begin
								result <= cnrf_pkg::sat50((W+2)'(a) - (W+2)'(b));
								done   <= 1'b1;
							end
							default: begin
								done <= 1'b1;
							end
						endcase
					end
				end
				MulRun: begin
					if (cnt_q == '0) begin
						result  <= cnrf_pkg::apply_sign(mul_mag, neg_q);
						done    <= 1'b1;
						state_q <= Idle;
					end else begin
						acc_q <= acc_next;
						mb_q  <= mb_q >> 1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				DivRun: begin
					if (cnt_q == '0) begin
						result  <= cnrf_pkg::apply_sign(quo_q, neg_q);
						done    <= 1'b1;
						state_q <= Idle;
					end else begin
						rem_q <= rem_next;
						num_q <= num_q << 1;
						quo_q <= quo_q[W] ? quo_q : {quo_q[W-1:0], qb};
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: state_q <= Idle;
			endcase
		end
	end
endmodule

// File: design/cubic_newton_root_finder_unit.sv
// ----------------------------------------------------------------------------
// cubic_newton_root_finder_unit
// newton-raphson root search on a configurable cubic
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | word
//  in       | input     | in_valid/in_stall  | initial_guess
//  out      | output    | out_valid/out_stall| root, status, iterations_used
//  cfg      | input     | cfg_we             | cfg_index, cfg_data
//
// one word at a time; a newton update runs seventeen operations on a
// shared serial unit: multiply and divide iterate bit by bit, while add
// and subtract are computed directly
// reset clears the sequencer and loads the default coefficients
// the result word waits in an output register; a new word is taken once it
// has been collected
module cubic_newton_root_finder_unit #(
	parameter int unsigned FRACTION_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [cnrf_pkg::WordW-1:0]   initial_guess,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [cnrf_pkg::WordW-1:0]   root,
	output logic [1:0]                          status,
	output logic [cnrf_pkg::IterW-1:0]          iterations_used,
	input  logic                                cfg_we,
	input  logic [2:0]                          cfg_index,
	input  logic [cnrf_pkg::WordW-1:0]          cfg_data
);
	localparam int unsigned W = cnrf_pkg::WordW;

	// configuration registers
	logic signed [W-1:0]               c0_q, c1_q, c2_q, c3_q;
	logic [cnrf_pkg::TolW-1:0]         tol_q;
	logic [cnrf_pkg::IterW-1:0]        maxit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c0_q    <= -48'sd32027705344;
			c1_q    <= 48'sd875770675;
			c2_q    <= 48'sd12582912;
			c3_q    <= -48'sd335544;
			tol_q   <= 47'd167772;
			maxit_q <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				cnrf_pkg::RegConstant: c0_q    <= cfg_data;
				cnrf_pkg::RegLinear:   c1_q    <= cfg_data;
				cnrf_pkg::RegSquare:   c2_q    <= cfg_data;
				cnrf_pkg::RegCube:     c3_q    <= cfg_data;
				cnrf_pkg::RegTol:      tol_q   <= cfg_data[cnrf_pkg::TolW-1:0];
				cnrf_pkg::RegMaxIter:  maxit_q <= cfg_data[cnrf_pkg::IterW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer steps; each arithmetic step issues one operation and waits for the unit
	typedef enum logic [4:0] {
		SIdle,
		SX2,      // x2 = x*x
		SX3,      // x3 = x2*x
		SLx,      // t1 = lin*x
		SSx2,     // t = sq*x2
		SAdd1,    // t = t1+t
		SCx3,     // t1 = cube*x3
		SAdd2,    // t = t+t1
		SAdd3,    // f = t+c0
		SCheckF,
		SPx,      // p = sq*x
		SCx2,     // c = cube*x2
		SPP,      // p = p+p
		SLp,      // t = lin+p
		SCC,      // t1 = c+c
		SCCC,     // t1 = t1+c
		SDf,      // d = t+t1
		SCheckD,
		SDiv,     // q = f/d, kept in t
		SNew,     // x1 = x-q, kept in t1
		SCheckS,
		SOut
	} seq_state_t;

	seq_state_t           state_q;
	logic                 first_q;     // residual check before any update
	logic signed [W-1:0]  x_q, x2_q, x3_q, t_q, t1_q, f_q, p_q, c_q, d_q;
	logic [cnrf_pkg::IterW-1:0] it_q;
	logic                 wait_q;      // operation issued, waiting for done

	cnrf_pkg::alu_cmd_t   cmd;
	logic signed [W-1:0]  op_a, op_b;
	logic                 alu_done;
	logic signed [W-1:0]  alu_res;

	cnrf_alu #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.a      (op_a),
		.b      (op_b),
		.done   (alu_done),
		.result (alu_res)
	);

	// operand selection per step
	always_comb begin
		cmd.op = cnrf_pkg::OpMul;
		op_a   = x_q;
		op_b   = x_q;
		case (state_q)
			SX2:   begin op_a = x_q;  op_b = x_q; end
			SX3:   begin op_a = x2_q; op_b = x_q; end
			SLx:   begin op_a = c1_q; op_b = x_q; end
			SSx2:  begin op_a = c2_q; op_b = x2_q; end
			SAdd1: begin cmd.op = cnrf_pkg::OpAdd; op_a = t1_q; op_b = t_q; end
			SCx3:  begin op_a = c3_q; op_b = x3_q; end
			SAdd2: begin cmd.op = cnrf_pkg::OpAdd; op_a = t_q; op_b = t1_q; end
			SAdd3: begin cmd.op = cnrf_pkg::OpAdd; op_a = t_q; op_b = c0_q; end
			SPx:   begin op_a = c2_q; op_b = x_q; end
			SCx2:  begin op_a = c3_q; op_b = x2_q; end
			SPP:   begin cmd.op = cnrf_pkg::OpAdd; op_a = p_q; op_b = p_q; end
			SLp:   begin cmd.op = cnrf_pkg::OpAdd; op_a = c1_q; op_b = p_q; end
			SCC:   begin cmd.op = cnrf_pkg::OpAdd; op_a = c_q; op_b = c_q; end
			SCCC:  begin cmd.op = cnrf_pkg::OpAdd; op_a = t1_q; op_b = c_q; end
			SDf:   begin cmd.op = cnrf_pkg::OpAdd; op_a = t_q; op_b = t1_q; end
			SDiv:  begin cmd.op = cnrf_pkg::OpDiv; op_a = f_q; op_b = d_q; end
			SNew:  begin cmd.op = cnrf_pkg::OpSub; op_a = x_q; op_b = t_q; end
			default: ;
		endcase
		cmd.start = !wait_q && (state_q != SIdle) && (state_q != SCheckF) &&
			(state_q != SCheckD) && (state_q != SCheckS) && (state_q != SOut);
	end

	// magnitudes for the tolerance tests; |x1-x| is exact, so one bit wider
	logic [W-1:0]  abs_f, abs_d;
	logic signed [W:0] step;
	logic [W:0]    abs_s;

	always_comb begin
		abs_f = f_q[W-1] ? W'(-f_q) : W'(f_q);
		abs_d = d_q[W-1] ? W'(-d_q) : W'(d_q);
		step  = (W+1)'(t1_q) - (W+1)'(x_q);
		abs_s = step[W] ? (W+1)'(-step) : (W+1)'(step);
	end

	assign in_stall = (state_q != SIdle);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SIdle;
			wait_q    <= 1'b0;
			out_valid <= 1'b0;
			first_q   <= 1'b0;
			it_q      <= '0;
		end else begin
			if (cmd.start) begin
				wait_q <= 1'b1;
			end
			if (alu_done) begin
				wait_q <= 1'b0;
			end
			case (state_q)
				SIdle: begin
					if (in_valid) begin
						x_q     <= initial_guess;
						first_q <= 1'b1;
						it_q    <= '0;
						state_q <= SX2;
					end
				end
				SOut: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= SIdle;
					end
				end
				SCheckF: begin
					if (first_q && ({1'b0, abs_f} < {2'b00, tol_q})) begin
						root      <= x_q;
						status    <= cnrf_pkg::StatusConverged;
						iterations_used <= '0;
						out_valid <= 1'b1;
						state_q   <= SOut;
					end else if (it_q >= maxit_q) begin
						root      <= '0;
						status    <= cnrf_pkg::StatusLimit;
						iterations_used <= it_q;
						out_valid <= 1'b1;
						state_q   <= SOut;
					end else begin
						first_q <= 1'b0;
						state_q <= SPx;
					end
				end
				SCheckD: begin
					if ({1'b0, abs_d} < {2'b00, tol_q}) begin
						root      <= '0;
						status    <= cnrf_pkg::StatusFlat;
						iterations_used <= it_q;
						out_valid <= 1'b1;
						state_q   <= SOut;
					end else begin
						state_q <= SDiv;
					end
				end
				SCheckS: begin
					if (abs_s < {2'b00, tol_q}) begin
						root      <= t1_q;
						status    <= cnrf_pkg::StatusConverged;
						iterations_used <= it_q;
						out_valid <= 1'b1;
						state_q   <= SOut;
					end else begin
						x_q     <= t1_q;
						state_q <= SX2;
					end
				end
				default: begin
					if (alu_done) begin
						case (state_q)
							SX2:   begin x2_q <= alu_res; state_q <= SX3; end
							SX3:   begin x3_q <= alu_res; state_q <= SLx; end
							SLx:   begin t1_q <= alu_res; state_q <= SSx2; end
							SSx2:  begin t_q  <= alu_res; state_q <= SAdd1; end
							SAdd1: begin t_q  <= alu_res; state_q <= SCx3; end
							SCx3:  begin t1_q <= alu_res; state_q <= SAdd2; end
							SAdd2: begin t_q  <= alu_res; state_q <= SAdd3; end
							SAdd3: begin f_q  <= alu_res; state_q <= SCheckF; end
							SPx:   begin p_q  <= alu_res; state_q <= SCx2; end
							SCx2:  begin c_q  <= alu_res; state_q <= SPP; end
							SPP:   begin p_q  <= alu_res; state_q <= SLp; end
							SLp:   begin t_q  <= alu_res; state_q <= SCC; end
							SCC:   begin t1_q <= alu_res; state_q <= SCCC; end
							SCCC:  begin t1_q <= alu_res; state_q <= SDf; end
							SDf:   begin d_q  <= alu_res; state_q <= SCheckD; end
							// quotient kept as is; the subtract saturates only once
							SDiv:  begin t_q  <= alu_res; state_q <= SNew; end
							SNew: begin
								t1_q    <= alu_res;
								it_q    <= it_q + 1'b1;
								state_q <= SCheckS;
							end
							default: state_q <= SIdle;
						endcase
					end
				end
			endcase
		end
	end

	// a result word only leaves with a legal status
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != 2'd3))
		else $error("illegal status");

	// non-converged words carry a zero root
	a_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != cnrf_pkg::StatusConverged) |-> (root == '0))
		else $error("root not cleared");

	// no word is taken while a result is pending
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while busy");

	// the update count never passes the limit
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (iterations_used <= maxit_q))
		else $error("iteration count over limit");

endmodule
